// ===== src/gtc_pkg.sv =====
// Shared types and constants of the graph triangle counter.
package gtc_pkg;

    // Graph size and field widths
    localparam int unsigned GTC_NODES = 64;
    localparam int unsigned NODE_W    = 6;
    localparam int unsigned ROW_W     = GTC_NODES;
    localparam int unsigned NCNT_W    = 7;
    localparam int unsigned TRI_W     = 16;
    localparam int unsigned EDGE_W    = 11;
    localparam int unsigned REJ_W     = 12;
    localparam int unsigned POP_W     = 7;

    // Configuration port
    localparam int unsigned ADDR_W    = 3;
    localparam int unsigned DATA_W    = 32;

    // Register index codes (index is byte address / 4)
    localparam logic REG_NODE_COUNT   = 1'b0;

    // Constant values
    localparam logic [NCNT_W-1:0] NCNT_RESET = NCNT_W'(GTC_NODES);
    localparam logic [NCNT_W-1:0] NCNT_MAX   = NCNT_W'(GTC_NODES);
    localparam logic [EDGE_W-1:0] EDGE_MAX   = '1;
    localparam logic [REJ_W-1:0]  REJ_MAX    = '1;
    localparam logic [NODE_W-1:0] NODE_LAST  = NODE_W'(GTC_NODES - 1);
    localparam logic [NODE_W-1:0] ROW_LAST   = NODE_W'(GTC_NODES - 2);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CROW,
        ST_CSCAN,
        ST_DRAIN,
        ST_DONE
    } gtc_state_t;

endpackage

// ===== src/graph_triangle_counter.sv =====
// Graph triangle counter: adjacency memory load, triangle scan and result register.
//
// Channel   Direction  Handshake                     Payload
// in        input      in_valid / in_ready           node_a, node_b, edge_present, last_edge
// out       output     out_valid / out_ready         triangle_count, edge_count, rejected_count
// apb       input      psel, penable, pwrite, pready paddr, pwdata, prdata (node_count)
//
// Edges are accepted back to back: the upper-triangle row is read from the adjacency
// memory and written back in the next cycle, with forwarding between back-to-back edges
// on one row. The last item stalls input while the memory port walks every row pair u < v:
// the last edge finishes, each row u is read and then every row v above it, the pipeline
// drains and the result is loaded; the stall also covers any wait for an earlier result.
// Reset clears the per-row valid bits at once, so no clearing pass is needed; the same
// bits are cleared in the same cycle that the result is loaded into the output register.
// Loading of the next graph proceeds while a result waits in the output register.
module graph_triangle_counter
    import gtc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // edge input
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [NODE_W-1:0]   node_a,
    input  logic [NODE_W-1:0]   node_b,
    input  logic                edge_present,
    input  logic                last_edge,
    // result output
    output logic                out_valid,
    input  logic                out_ready,
    output logic [TRI_W-1:0]    triangle_count,
    output logic [EDGE_W-1:0]   edge_count,
    output logic [REJ_W-1:0]    rejected_count,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    // Adjacency memory: row r holds bit c set for each edge (r, c) with c > r
    logic [ROW_W-1:0] adj_mem [GTC_NODES];

    // Control registers
    gtc_state_t          state_reg, state_next;
    logic [NCNT_W-1:0]   node_count_reg, node_count_next;
    logic [ROW_W-1:0]    row_valid_reg, row_valid_next;
    logic                s1_act_reg, s1_act_next;
    logic                s1_ok_reg, s1_ok_next;
    logic                s1_last_reg, s1_last_next;
    logic                fwd_hit_reg, fwd_hit_next;
    logic                rd_valid_reg, rd_valid_next;
    logic                rowu_load_reg, rowu_load_next;
    logic                p1_valid_reg, p1_valid_next;
    logic                p2_valid_reg, p2_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic [NODE_W-1:0]   u_reg, u_next;
    logic [NODE_W-1:0]   v_reg, v_next;
    logic [EDGE_W-1:0]   edge_cnt_reg, edge_cnt_next;
    logic [REJ_W-1:0]    rej_cnt_reg, rej_cnt_next;
    logic [TRI_W-1:0]    tri_acc_reg, tri_acc_next;

    // Data registers
    logic [ROW_W-1:0]    rd_data_reg;
    logic [NODE_W-1:0]   s1_row_reg, s1_row_next;
    logic [NODE_W-1:0]   s1_col_reg, s1_col_next;
    logic [ROW_W-1:0]    fwd_data_reg, fwd_data_next;
    logic [ROW_W-1:0]    rowu_reg, rowu_next;
    logic [NODE_W-1:0]   p1_v_reg, p1_v_next;
    logic [ROW_W-1:0]    and_reg, and_next;
    logic [TRI_W-1:0]    tri_out_reg, tri_out_next;
    logic [EDGE_W-1:0]   edge_out_reg, edge_out_next;
    logic [REJ_W-1:0]    rej_out_reg, rej_out_next;

    // Combinational helpers
    logic                in_fire;
    logic                cfg_write;
    logic [NCNT_W-1:0]   limit;
    logic                edge_ok;
    logic [NODE_W-1:0]   node_lo;
    logic [NODE_W-1:0]   node_hi;
    logic [NODE_W-1:0]   rd_addr;
    logic [ROW_W-1:0]    rd_eff;
    logic [ROW_W-1:0]    s1_row_data;
    logic                s1_wr;
    logic [ROW_W-1:0]    wr_data;

    // Count set bits: byte counts first, then their sum
    function automatic logic [POP_W-1:0] pop_count(input logic [ROW_W-1:0] x);
        logic [3:0]       byte_cnt [ROW_W/8];
        logic [POP_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < ROW_W/8; i++) begin
            byte_cnt[i] = '0;
            for (int j = 0; j < 8; j++) begin
                byte_cnt[i] = byte_cnt[i] + 4'(x[i*8+j]);
            end
        end
        for (int i = 0; i < ROW_W/8; i++) begin
            sum = sum + POP_W'(byte_cnt[i]);
        end
        return sum;
    endfunction

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT)
                       && (paddr[1:0] == 2'b00);
    assign prdata    = (paddr[2] == REG_NODE_COUNT) ? DATA_W'(node_count_reg) : '0;

    // Input checks
    assign in_ready = (state_reg == ST_LOAD) && !(s1_act_reg && s1_last_reg);
    assign in_fire  = in_valid && in_ready;
    assign limit    = (node_count_reg > NCNT_MAX) ? NCNT_MAX : node_count_reg;
    assign edge_ok  = edge_present && (node_a != node_b)
                      && ({1'b0, node_a} < limit) && ({1'b0, node_b} < limit);
    assign node_lo  = (node_a < node_b) ? node_a : node_b;
    assign node_hi  = (node_a < node_b) ? node_b : node_a;

    // Row read data, zero for rows never written since the last clear
    assign rd_eff      = rd_valid_reg ? rd_data_reg : '0;
    assign s1_row_data = fwd_hit_reg ? fwd_data_reg : rd_eff;
    assign s1_wr       = s1_act_reg && s1_ok_reg && !s1_row_data[s1_col_reg];
    assign wr_data     = s1_row_data | (ROW_W'(1) << s1_col_reg);

    // Memory address select
    always_comb
    begin
        case (state_reg)
            ST_CROW:  rd_addr = u_reg;
            ST_CSCAN: rd_addr = v_reg;
            default:  rd_addr = node_lo;
        endcase
    end

    // Next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        row_valid_next  = row_valid_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        edge_cnt_next   = edge_cnt_reg;
        rej_cnt_next    = rej_cnt_reg;
        tri_acc_next    = tri_acc_reg;
        rowu_load_next  = 1'b0;
        p1_valid_next   = 1'b0;
        p1_v_next       = v_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        tri_out_next    = tri_out_reg;
        edge_out_next   = edge_out_reg;
        rej_out_next    = rej_out_reg;

        // node count register write
        if (cfg_write)
        begin
            node_count_next = pwdata[NCNT_W-1:0];
        end

        // stage 1 of the load pipeline
        s1_act_next   = in_fire;
        s1_ok_next    = edge_ok;
        s1_last_next  = last_edge;
        s1_row_next   = node_lo;
        s1_col_next   = node_hi;
        rd_valid_next = row_valid_reg[rd_addr];
        fwd_hit_next  = s1_wr && in_fire && edge_ok && (node_lo == s1_row_reg);
        fwd_data_next = wr_data;

        // count rejected transfers, saturating
        if (in_fire && edge_present && !edge_ok && (rej_cnt_reg != REJ_MAX))
        begin
            rej_cnt_next = rej_cnt_reg + REJ_W'(1);
        end

        // write back a new edge
        if (s1_wr)
        begin
            row_valid_next[s1_row_reg] = 1'b1;
            if (edge_cnt_reg != EDGE_MAX)
            begin
                edge_cnt_next = edge_cnt_reg + EDGE_W'(1);
            end
        end

        // capture row u in the cycle after its read
        rowu_next = rowu_load_reg ? rd_eff : rowu_reg;

        // intersect row u with row v when edge (u, v) exists
        and_next      = (p1_valid_reg && rowu_reg[p1_v_reg]) ? (rowu_reg & rd_eff) : '0;
        p2_valid_next = p1_valid_reg;

        // accumulate common neighbors above v
        if (p2_valid_reg)
        begin
            tri_acc_next = tri_acc_reg + TRI_W'(pop_count(and_reg));
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (s1_act_reg && s1_last_reg)
                begin
                    u_next     = '0;
                    state_next = ST_CROW;
                end
            end
            ST_CROW:
            begin
                rowu_load_next = 1'b1;
                v_next         = u_reg + NODE_W'(1);
                state_next     = ST_CSCAN;
            end
            ST_CSCAN:
            begin
                p1_valid_next = 1'b1;
                if (v_reg == NODE_LAST)
                begin
                    if (u_reg == ROW_LAST)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        u_next     = u_reg + NODE_W'(1);
                        state_next = ST_CROW;
                    end
                end
                else
                begin
                    v_next = v_reg + NODE_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!p1_valid_reg && !p2_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // load result once the output register is free, then clear the store
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    tri_out_next   = tri_acc_reg;
                    edge_out_next  = edge_cnt_reg;
                    rej_out_next   = rej_cnt_reg;
                    row_valid_next = '0;
                    edge_cnt_next  = '0;
                    rej_cnt_next   = '0;
                    tri_acc_next   = '0;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Adjacency memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (s1_wr)
        begin
            adj_mem[s1_row_reg] <= wr_data;
        end
        rd_data_reg <= adj_mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            node_count_reg <= NCNT_RESET;
            row_valid_reg  <= '0;
            s1_act_reg     <= 1'b0;
            s1_ok_reg      <= 1'b0;
            s1_last_reg    <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            rd_valid_reg   <= 1'b0;
            rowu_load_reg  <= 1'b0;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            u_reg          <= '0;
            v_reg          <= '0;
            edge_cnt_reg   <= '0;
            rej_cnt_reg    <= '0;
            tri_acc_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            row_valid_reg  <= row_valid_next;
            s1_act_reg     <= s1_act_next;
            s1_ok_reg      <= s1_ok_next;
            s1_last_reg    <= s1_last_next;
            fwd_hit_reg    <= fwd_hit_next;
            rd_valid_reg   <= rd_valid_next;
            rowu_load_reg  <= rowu_load_next;
            p1_valid_reg   <= p1_valid_next;
            p2_valid_reg   <= p2_valid_next;
            out_valid_reg  <= out_valid_next;
            u_reg          <= u_next;
            v_reg          <= v_next;
            edge_cnt_reg   <= edge_cnt_next;
            rej_cnt_reg    <= rej_cnt_next;
            tri_acc_reg    <= tri_acc_next;
        end
    end

    // Data registers
    always_ff @(posedge clk)
    begin
        s1_row_reg   <= s1_row_next;
        s1_col_reg   <= s1_col_next;
        fwd_data_reg <= fwd_data_next;
        rowu_reg     <= rowu_next;
        p1_v_reg     <= p1_v_next;
        and_reg      <= and_next;
        tri_out_reg  <= tri_out_next;
        edge_out_reg <= edge_out_next;
        rej_out_reg  <= rej_out_next;
    end

    // Drive outputs
    assign out_valid      = out_valid_reg;
    assign triangle_count = tri_out_reg;
    assign edge_count     = edge_out_reg;
    assign rejected_count = rej_out_reg;

`ifndef ASSERT_OFF
    // Stored edges always sit above the diagonal
    a_upper_triangle: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_act_reg && s1_ok_reg) |-> (s1_col_reg > s1_row_reg))
        else $error("edge stored on or below the diagonal");

    // No transfer is taken while the scan pipeline holds data
    a_ready_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!p1_valid_reg && !p2_valid_reg && !rowu_load_reg))
        else $error("input ready while the scan pipeline is busy");

    // The result is loaded only after the scan pipeline has drained
    a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (!p1_valid_reg && !p2_valid_reg))
        else $error("result loaded before the scan drained");

    // A new result appears only from the done state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the done state");
`endif

endmodule
